@@ design/value_log_record_appender_top_macros.svh @@
// Assertion macros for the value log record appender.
// Used by value_log_record_appender_top; expects clk and arst_n in scope.
`ifndef VALUE_LOG_RECORD_APPENDER_TOP_MACROS_SVH
`define VALUE_LOG_RECORD_APPENDER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define VLRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define VLRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/vlra_pkg.sv @@
// Shared types, codes and CRC-32 helpers for the value log record appender.
// No dependencies; imported by every design module.
package vlra_pkg;

	localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam int VALUE_HEAD     = 12;
	localparam int ENTRY_OVERHEAD = 13;

	localparam logic [47:0] MAX_SEG_RESET   = 48'd67108864;
	localparam logic [20:0] BUF_BYTES_RESET = 21'd4096;
	localparam logic [31:0] FIRST_SEG_RESET = 32'd0;

	// result queue; depth must be a power of two
	localparam int OUT_DEPTH = 8;
	localparam int PTR_W     = $clog2(OUT_DEPTH);
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
	localparam int MAX_RES   = 2;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_KEY   = 2'd1,
		CMD_VALUE = 2'd2,
		CMD_FLUSH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_PLACE = 2'd0,
		KIND_CRC   = 2'd1,
		KIND_FLUSH = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_KEY   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CFG_MAX_SEG   = 2'd0,
		CFG_BUF_BYTES = 2'd1,
		CFG_FIRST_SEG = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] key_length;
		logic [31:0] value_length;
		logic [7:0]  value_type;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] segment_id;
		logic [31:0] stored_value_length;
		logic [47:0] value_offset;
		logic        rotated;
		logic        bypass_buffer;
		logic [20:0] flushed_bytes;
		logic [31:0] record_crc;
		logic        last;
	} res_t;

	// results produced by one item: count, then up to two words
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic res_t mk_res(input kind_t kind, input logic [31:0] seg,
			input logic [31:0] vlen, input logic [47:0] off, input logic rot,
			input logic byp, input logic [20:0] fl, input logic [31:0] crc,
			input logic lst);
		res_t r;
		r.kind                = kind;
		r.segment_id          = seg;
		r.stored_value_length = vlen;
		r.value_offset        = off;
		r.rotated             = rot;
		r.bypass_buffer       = byp;
		r.flushed_bytes       = fl;
		r.record_crc          = crc;
		r.last                = lst;
		return r;
	endfunction

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// four bytes, little-endian
	function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
		logic [31:0] c;
		c = crc;
		for (int i = 0; i < 4; i++) begin
			c = crc_byte(c, w[8*i +: 8]);
		end
		return c;
	endfunction

endpackage

@@ design/vlra_engine.sv @@
// Placement, buffer accounting and record CRC for one registered item per cycle.
// Depends on vlra_pkg.
module vlra_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  vlra_pkg::item_t   item_s1,
	input  logic [47:0]       max_seg,
	input  logic [20:0]       buf_bytes,
	input  logic              seg_load,
	input  logic [31:0]       seg_load_val,
	output vlra_pkg::push_t   push
);
	import vlra_pkg::*;

	logic [31:0] seg_q, seg_n;
	logic [47:0] written_q, written_n;
	logic [20:0] fill_q, fill_n;
	logic [31:0] crc_q, crc_n;
	phase_t      phase_q, phase_n;
	logic [31:0] left_q, left_n;
	logic [31:0] hvlen_q, hvlen_n;
	logic [7:0]  htag_q, htag_n;

	always_comb begin
		logic [33:0] total;
		logic [49:0] need;
		logic        rot;
		logic        byp;
		logic        over;
		logic [47:0] w;
		logic [20:0] f;
		logic [34:0] over_sum;
		logic [47:0] start;
		logic [47:0] offset;
		logic [31:0] crc0;
		logic [31:0] crc_hdr;
		logic [31:0] c;
		logic [20:0] fl;

		seg_n     = seg_q;
		written_n = written_q;
		fill_n    = fill_q;
		crc_n     = crc_q;
		phase_n   = phase_q;
		left_n    = left_q;
		hvlen_n   = hvlen_q;
		htag_n    = htag_q;
		push.n    = 2'd0;
		push.r0   = mk_res(KIND_PLACE, '0, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0);
		push.r1   = push.r0;

		total    = 34'(ENTRY_OVERHEAD) + 34'(item_s1.key_length) + 34'(item_s1.value_length);
		need     = 50'(written_q) + 50'(fill_q) + 50'(total);
		rot      = need > 50'(max_seg);
		w        = rot ? '0 : written_q;
		f        = rot ? '0 : fill_q;
		byp      = total > 34'(buf_bytes);
		over_sum = 35'(f) + 35'(total);
		over     = over_sum > 35'(buf_bytes);
		// the entry lands after everything written or buffered so far in its segment
		start    = w + 48'(f);
		offset   = start + 48'(VALUE_HEAD) + 48'(item_s1.key_length);
		fl       = (rot || byp || over) ? fill_q : '0;
		crc0     = crc_word(CRC_PRESET, item_s1.key_length);
		crc_hdr  = crc_byte(crc_word(crc0, item_s1.value_length), item_s1.value_type);
		c        = crc_byte(crc_q, item_s1.data_byte);

		if (valid_s1) begin
			case (item_s1.cmd)
				CMD_START: begin
					seg_n   = seg_q + 32'(rot);
					hvlen_n = item_s1.value_length;
					htag_n  = item_s1.value_type;
					if (byp) begin
						written_n = start + 48'(total);
						fill_n    = '0;
					end else if (over) begin
						written_n = start;
						fill_n    = 21'(total);
					end else begin
						written_n = w;
						fill_n    = f + 21'(total);
					end
					push.n  = 2'd1;
					push.r0 = mk_res(KIND_PLACE, seg_n, item_s1.value_length, offset,
						rot, byp, fl, '0, 1'b1);
					if (item_s1.key_length != '0) begin
						crc_n   = crc0;
						phase_n = PH_KEY;
						left_n  = item_s1.key_length;
					end else if (item_s1.value_length != '0) begin
						crc_n   = crc_hdr;
						phase_n = PH_VALUE;
						left_n  = item_s1.value_length;
					end else begin
						// empty record: checksum follows the placement
						crc_n      = crc_hdr;
						phase_n    = PH_IDLE;
						left_n     = '0;
						push.n     = 2'd2;
						push.r0.last = 1'b0;
						push.r1    = mk_res(KIND_CRC, seg_n, '0, '0, 1'b0, 1'b0, '0,
							~crc_hdr, 1'b1);
					end
				end
				CMD_FLUSH: begin
					written_n = written_q + 48'(fill_q);
					fill_n    = '0;
					push.n    = 2'd1;
					push.r0   = mk_res(KIND_FLUSH, seg_q, '0, '0, 1'b0, 1'b0, fill_q,
						'0, 1'b1);
				end
				CMD_KEY: begin
					if (phase_q == PH_KEY && left_q != '0) begin
						left_n = left_q - 32'd1;
						crc_n  = c;
						if (left_q == 32'd1) begin
							// key done: fold value length and tag
							crc_n = crc_byte(crc_word(c, hvlen_q), htag_q);
							if (hvlen_q == '0) begin
								phase_n = PH_IDLE;
								push.n  = 2'd1;
								push.r0 = mk_res(KIND_CRC, seg_q, hvlen_q, '0, 1'b0, 1'b0,
									'0, ~crc_n, 1'b1);
							end else begin
								phase_n = PH_VALUE;
								left_n  = hvlen_q;
							end
						end
					end
				end
				CMD_VALUE: begin
					if (phase_q == PH_VALUE && left_q != '0) begin
						left_n = left_q - 32'd1;
						crc_n  = c;
						if (left_q == 32'd1) begin
							phase_n = PH_IDLE;
							push.n  = 2'd1;
							push.r0 = mk_res(KIND_CRC, seg_q, hvlen_q, '0, 1'b0, 1'b0,
								'0, ~c, 1'b1);
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (seg_load) begin
			seg_n = seg_load_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= FIRST_SEG_RESET;
			written_q <= '0;
			fill_q    <= '0;
			crc_q     <= CRC_PRESET;
			phase_q   <= PH_IDLE;
			left_q    <= '0;
			hvlen_q   <= '0;
			htag_q    <= '0;
		end else begin
			seg_q     <= seg_n;
			written_q <= written_n;
			fill_q    <= fill_n;
			crc_q     <= crc_n;
			phase_q   <= phase_n;
			left_q    <= left_n;
			hvlen_q   <= hvlen_n;
			htag_q    <= htag_n;
		end
	end

endmodule

@@ design/vlra_out_fifo.sv @@
// Result queue: takes up to two words a cycle, hands out one.
// Depends on vlra_pkg.
module vlra_out_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vlra_pkg::push_t         push,
	input  logic                    pop,
	output logic                    valid,
	output vlra_pkg::res_t          head,
	output logic [vlra_pkg::CNT_W-1:0] count
);
	import vlra_pkg::*;

	res_t             mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign valid = cnt_q != '0;
	assign head  = mem_q[rd_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.n);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

endmodule

@@ design/value_log_record_appender_top.sv @@
// Value log record appender, top level: input register, configuration registers,
// engine and result queue. Depends on vlra_pkg, vlra_engine, vlra_out_fifo.
//
// Input channel (in_valid/in_stall): one command word per cycle - start entry, key
// byte, value byte or forced flush. Output channel (out_valid/out_stall): result
// words, placement, record checksum or flush report; last marks the final word of
// an input word. A start of an empty record gives two words, anything else one or
// none (stray data bytes are dropped silently).
// A taken word goes into the input register and through the engine; its result
// is written into the result queue, whence it can be taken. Throughput is one
// word per cycle in steady flow; the engine with its header CRC unroll sets that.
// The input register feeds an eight-word result queue; in_stall rises once the
// queue plus the word in flight could not hold two more results, so out_stall
// backs up into the input only after several waiting results.
// Reset clears the queue, the entry state and loads the configuration registers
// with their defaults. Configuration writes (cfg_we, cfg_index, cfg_data) take
// effect at once and are meant for idle periods; writing the first segment id
// also switches the current segment.
module value_log_record_appender_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] key_length,
	input  logic [31:0] value_length,
	input  logic [7:0]  value_type,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [31:0] segment_id,
	output logic [31:0] stored_value_length,
	output logic [47:0] value_offset,
	output logic        rotated,
	output logic        bypass_buffer,
	output logic [20:0] flushed_bytes,
	output logic [31:0] record_crc,
	output logic        last
);
	import vlra_pkg::*;

	`include "value_log_record_appender_top_macros.svh"

	logic             valid_s1;
	item_t            item_s1;
	logic [47:0]      max_seg_q;
	logic [20:0]      buf_bytes_q;
	logic             seg_load;
	push_t            push;
	res_t             head;
	logic [CNT_W-1:0] fifo_count;
	logic             accept;
	logic             pop;
	logic [CNT_W:0]   reserved;

	// reserve room for the word in flight and the one being taken
	assign reserved = {1'b0, fifo_count} + (valid_s1 ? (CNT_W+1)'(MAX_RES) : '0);
	assign in_stall = reserved > (CNT_W+1)'(OUT_DEPTH - MAX_RES);
	assign accept   = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;
	assign seg_load = cfg_we && (cfg_index == CFG_FIRST_SEG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd          <= cmd_t'(cmd);
			item_s1.key_length   <= key_length;
			item_s1.value_length <= value_length;
			item_s1.value_type   <= value_type;
			item_s1.data_byte    <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seg_q   <= MAX_SEG_RESET;
			buf_bytes_q <= BUF_BYTES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_SEG:   max_seg_q   <= cfg_data;
				CFG_BUF_BYTES: buf_bytes_q <= cfg_data[20:0];
				default: begin
				end
			endcase
		end
	end

	vlra_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.max_seg      (max_seg_q),
		.buf_bytes    (buf_bytes_q),
		.seg_load     (seg_load),
		.seg_load_val (cfg_data[31:0]),
		.push         (push)
	);

	vlra_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.valid  (out_valid),
		.head   (head),
		.count  (fifo_count)
	);

	assign result_kind         = head.kind;
	assign segment_id          = head.segment_id;
	assign stored_value_length = head.stored_value_length;
	assign value_offset        = head.value_offset;
	assign rotated             = head.rotated;
	assign bypass_buffer       = head.bypass_buffer;
	assign flushed_bytes       = head.flushed_bytes;
	assign record_crc          = head.record_crc;
	assign last                = head.last;

	`VLRA_ASSERT_NOW(a_queue_room, push.n != 2'd0, (fifo_count + CNT_W'(push.n)) <= CNT_W'(OUT_DEPTH), "result queue overflow")
	`VLRA_ASSERT_NOW(a_pair_is_empty_record, push.n == 2'd2, (push.r0.kind == KIND_PLACE) && (push.r1.kind == KIND_CRC) && !push.r0.last && push.r1.last, "bad result pair")
	`VLRA_ASSERT_NEXT(a_accept_loads_s1, accept, valid_s1, "accepted word lost before engine")

endmodule
